/* src/ifmt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifmt_pkg: shared types and constants of the integer field formatter
// Holds the request and result item types, the conversion, size and pad
// codes, the character constants and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ifmt_pkg;

	// Conversion codes.
	localparam logic [2:0] CONV_OCT  = 3'd0;
	localparam logic [2:0] CONV_SDEC = 3'd1;
	localparam logic [2:0] CONV_UDEC = 3'd2;
	localparam logic [2:0] CONV_HEXL = 3'd3;
	localparam logic [2:0] CONV_HEXU = 3'd4;
	localparam logic [2:0] CONV_PTR  = 3'd5;
	localparam logic [2:0] CONV_CHAR = 3'd6;
	localparam logic [2:0] CONV_NONE = 3'd7;

	// Argument size codes; anything from SIZE_LL upward is 64-bit, except for pointers.
	localparam logic [1:0] SIZE_INT  = 2'd0;
	localparam logic [1:0] SIZE_LONG = 2'd1;
	localparam logic [1:0] SIZE_LL   = 2'd2;

	// Pad mode codes; the unused code behaves as PAD_SPACE.
	localparam logic [1:0] PAD_SPACE = 2'd0;
	localparam logic [1:0] PAD_ZERO  = 2'd1;
	localparam logic [1:0] PAD_LEFT  = 2'd2;

	// Characters.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_X     = 8'h78;

	// Longest field content: 22 octal digits of a 64-bit value.
	localparam int BODY_CAP = 22;
	localparam int BLEN_W   = $clog2(BODY_CAP + 1);
	localparam int BIDX_W   = $clog2(BODY_CAP);

	// Pointer fields are always eight hex digits behind the prefix.
	localparam int PTR_DIGITS = 8;

	typedef struct packed {
		logic [2:0]  conversion;
		logic [1:0]  arg_size;
		logic [1:0]  pad_mode;
		logic [5:0]  min_width;
		logic [63:0] arg_value;
	} req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
	} res_t;

	typedef struct packed {
		logic load;
		logic dabble_step;
		logic unpack_step;
		logic sign_put;
		logic setup;
		logic emit_step;
	} ctl_cmd_t;

	typedef struct packed {
		logic dabble_done;
		logic unpack_done;
		logic neg;
		logic emit_last;
	} ctl_sts_t;

endpackage

/* src/integer_field_formatter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_field_formatter_core: printf-style integer field formatter
// Turns one parsed conversion request into the characters of its field.
// ----------------------------------------------------------------------------
// Sequence: a decimal item first takes one BCD shift per argument bit;
// every item but a character then has its digits unpacked and, if negative,
// a minus added; then one character a cycle is issued, prefix plus the
// larger of width and content. Throughput: one item at a time; busy
// stays high until the last character is issued; the receiver cannot stall.
// Reset clears the sequencer and the result strobe; data registers are not.
module integer_field_formatter_core
	import ifmt_pkg::*;
#(
	parameter int MAX_WIDTH = 48
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output res_t result,
	output logic strobe
);

	// The controller only sequences; every value of an item lives in the
	// datapath. Status flows back as one struct, commands as another.
	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ifmt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.conversion (request.conversion),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy)
	);

	// The datapath registers each character together with its last flag, so
	// the result ports are driven straight from flops and a new item can be
	// accepted in the same cycle as the last character of the previous one.
	ifmt_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result),
		.strobe  (strobe)
	);

endmodule

/* src/ifmt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifmt_ctrl: sequencing state machine of the integer field formatter
// Steps the datapath through binary-to-BCD, digit unpacking, sign, pad
// setup and character emission.
// ----------------------------------------------------------------------------
module ifmt_ctrl
	import ifmt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] conversion,
	input  ctl_sts_t   sts,
	output ctl_cmd_t   cmd,
	output logic       busy
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DABBLE = 3'd1;
	localparam logic [2:0] ST_UNPACK = 3'd2;
	localparam logic [2:0] ST_SIGN   = 3'd3;
	localparam logic [2:0] ST_SETUP  = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start && conversion != CONV_NONE) begin
					cmd.load = 1'b1;
					if (conversion == CONV_SDEC || conversion == CONV_UDEC)
						state_d = ST_DABBLE;
					else if (conversion == CONV_CHAR)
						state_d = ST_SETUP;
					else
						state_d = ST_UNPACK;
				end
			end
			ST_DABBLE: begin
				cmd.dabble_step = 1'b1;
				if (sts.dabble_done)
					state_d = ST_UNPACK;
			end
			ST_UNPACK: begin
				cmd.unpack_step = 1'b1;
				if (sts.unpack_done)
					state_d = sts.neg ? ST_SIGN : ST_SETUP;
			end
			ST_SIGN: begin
				cmd.sign_put = 1'b1;
				state_d      = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_step = 1'b1;
				if (sts.emit_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* src/ifmt_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifmt_dp: datapath of the integer field formatter
// Holds the magnitude, the BCD shifter, the field content buffer, the pad
// counters and the registered result item.
// ----------------------------------------------------------------------------
module ifmt_dp
	import ifmt_pkg::*;
#(
	parameter int MAX_WIDTH = 48
) (
	input  logic     clk,
	input  logic     arst_n,
	input  req_t     request,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	output res_t     result,
	output logic     strobe
);

	localparam int WID_W   = $clog2(MAX_WIDTH + 1);
	localparam int LEN_MAX = ((MAX_WIDTH > BODY_CAP) ? MAX_WIDTH : BODY_CAP) + 2;
	localparam int LEN_W   = $clog2(LEN_MAX + 1);
	localparam int NDIG    = 20;

	// Load-time decode.
	logic        ld_wide;
	logic        ld_neg;
	logic [63:0] ld_mag;
	logic [WID_W-1:0] ld_width;

	// Item registers.
	logic        oct_q;
	logic [7:0]  alpha_q;
	logic        zpad_q;
	logic        left_q;
	logic [1:0]  pre_q;
	logic [WID_W-1:0] width_q;
	logic        neg_q;
	logic [79:0] src_q;
	logic [63:0] bin_q;
	logic [6:0]  dcnt_q;
	logic [BLEN_W-1:0] blen_q;
	logic [BLEN_W-1:0] brem_q;
	logic [LEN_W-1:0]  lead_q;
	logic [LEN_W-1:0]  trail_q;
	logic [LEN_W-1:0]  rem_q;
	logic [7:0]  body_q [BODY_CAP];
	res_t        res_q;
	logic        strobe_q;

	// Step logic.
	logic [79:0] bcd_adj;
	logic [79:0] src_next;
	logic [3:0]  dig;
	logic [7:0]  dig_char;
	logic [7:0]  emit_char;
	logic [BLEN_W-1:0] brem_m1;
	logic [LEN_W-1:0]  w_ext;
	logic [LEN_W-1:0]  b_ext;
	logic [LEN_W-1:0]  pad_cnt;
	logic        wr_en;
	logic [BIDX_W-1:0] wr_idx;
	logic [7:0]  wr_data;

	always_comb begin
		ld_wide = (request.arg_size >= SIZE_LL) && (request.conversion != CONV_PTR);
		if (ld_wide) begin
			ld_neg = (request.conversion == CONV_SDEC) && request.arg_value[63];
			ld_mag = ld_neg ? (64'd0 - request.arg_value) : request.arg_value;
		end else begin
			ld_neg = (request.conversion == CONV_SDEC) && request.arg_value[31];
			ld_mag = ld_neg ? {32'd0, 32'd0 - request.arg_value[31:0]}
			                : {32'd0, request.arg_value[31:0]};
		end
		if (request.conversion == CONV_PTR)
			ld_width = WID_W'(PTR_DIGITS);
		else if ({{(WID_W + 1){1'b0}}, request.min_width} >
		         (WID_W + 7)'(MAX_WIDTH))
			ld_width = WID_W'(MAX_WIDTH);
		else
			ld_width = WID_W'(request.min_width);
	end

	// Add three to every BCD digit of five or more before the shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (src_q[i*4 +: 4] >= 4'd5)
				bcd_adj[i*4 +: 4] = src_q[i*4 +: 4] + 4'd3;
			else
				bcd_adj[i*4 +: 4] = src_q[i*4 +: 4];
		end
	end

	always_comb begin
		src_next = oct_q ? (src_q >> 3) : (src_q >> 4);
		dig      = oct_q ? {1'b0, src_q[2:0]} : src_q[3:0];
		if (dig > 4'd9)
			dig_char = alpha_q + {4'd0, dig - 4'd10};
		else
			dig_char = CH_ZERO + {4'd0, dig};
	end

	assign sts.dabble_done = (dcnt_q == 7'd1);
	assign sts.unpack_done = (src_next == 80'd0);
	assign sts.neg         = neg_q;
	assign sts.emit_last   = (rem_q == LEN_W'(1));

	// Pad length once the content length is known.
	always_comb begin
		w_ext = LEN_W'(width_q);
		b_ext = LEN_W'(blen_q);
		pad_cnt = (w_ext > b_ext) ? (w_ext - b_ext) : '0;
	end

	// Character for the current emission slot: prefix, leading pad, content,
	// trailing pad, in that order.
	assign brem_m1 = brem_q - BLEN_W'(1);
	always_comb begin
		if (pre_q == 2'd2)
			emit_char = CH_ZERO;
		else if (pre_q == 2'd1)
			emit_char = CH_X;
		else if (lead_q != '0)
			emit_char = zpad_q ? CH_ZERO : CH_SPACE;
		else if (brem_q != '0)
			emit_char = body_q[brem_m1[BIDX_W-1:0]];
		else
			emit_char = CH_SPACE;
	end

	// Content buffer write port.
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = blen_q[BIDX_W-1:0];
		wr_data = dig_char;
		if (cmd.load && request.conversion == CONV_CHAR) begin
			wr_en   = 1'b1;
			wr_idx  = '0;
			wr_data = request.arg_value[7:0];
		end else if (cmd.unpack_step) begin
			wr_en = 1'b1;
		end else if (cmd.sign_put) begin
			wr_en   = 1'b1;
			wr_data = CH_MINUS;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			body_q[wr_idx] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			oct_q   <= (request.conversion == CONV_OCT);
			alpha_q <= (request.conversion == CONV_HEXL) ? CH_LA : CH_UA;
			zpad_q  <= (request.conversion == CONV_PTR) ||
			           ((request.conversion != CONV_CHAR) && (request.pad_mode == PAD_ZERO));
			left_q  <= (request.conversion != CONV_PTR) && (request.pad_mode == PAD_LEFT);
			pre_q   <= (request.conversion == CONV_PTR) ? 2'd2 : 2'd0;
			width_q <= ld_width;
			neg_q   <= ld_neg;
			if (request.conversion == CONV_SDEC || request.conversion == CONV_UDEC)
				src_q <= '0;
			else
				src_q <= {16'd0, ld_mag};
			bin_q   <= ld_wide ? ld_mag : {ld_mag[31:0], 32'd0};
			dcnt_q  <= ld_wide ? 7'd64 : 7'd32;
			blen_q  <= (request.conversion == CONV_CHAR) ? BLEN_W'(1) : '0;
		end else if (cmd.dabble_step) begin
			src_q  <= {bcd_adj[78:0], bin_q[63]};
			bin_q  <= {bin_q[62:0], 1'b0};
			dcnt_q <= dcnt_q - 7'd1;
		end else if (cmd.unpack_step) begin
			src_q  <= src_next;
			blen_q <= blen_q + BLEN_W'(1);
		end else if (cmd.sign_put) begin
			blen_q <= blen_q + BLEN_W'(1);
		end else if (cmd.setup) begin
			brem_q  <= blen_q;
			lead_q  <= left_q ? '0 : pad_cnt;
			trail_q <= left_q ? pad_cnt : '0;
			rem_q   <= LEN_W'(pre_q) + b_ext + pad_cnt;
		end else if (cmd.emit_step) begin
			rem_q <= rem_q - LEN_W'(1);
			if (pre_q != 2'd0)
				pre_q <= pre_q - 2'd1;
			else if (lead_q != '0)
				lead_q <= lead_q - LEN_W'(1);
			else if (brem_q != '0)
				brem_q <= brem_m1;
			else
				trail_q <= trail_q - LEN_W'(1);
		end
	end

	// Registered result item.
	always_ff @(posedge clk) begin
		if (cmd.emit_step) begin
			res_q.out_char <= emit_char;
			res_q.last     <= sts.emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= cmd.emit_step;
	end

	assign result = res_q;
	assign strobe = strobe_q;

endmodule
